/* sv/rrt_pkg.sv */
// Shared types and constants for the register rename table.
// Holds operation and error codes, the control and status structs of the free list, and the request and result structs.
// No dependencies.
package rrt_pkg;

    localparam int NUM_PHYS    = 16;
    localparam int NUM_LOGICAL = 8;
    localparam int PHYS_W      = 4;
    localparam int LOG_W       = 3;
    localparam int MODE_W      = 4;
    localparam int ERR_W       = 3;
    localparam int CNT_W       = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC       = 4'd0,
        MODE_FREE        = 4'd1,
        MODE_LOCK        = 4'd2,
        MODE_RELEASE     = 4'd3,
        MODE_CHECK_LOCK  = 4'd4,
        MODE_MAP_WRITE   = 4'd5,
        MODE_MAP_READ    = 4'd6,
        MODE_SET_READY   = 4'd7,
        MODE_READ_READY  = 4'd8
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK           = 3'd0,
        ERR_ALLOC_EMPTY  = 3'd1,
        ERR_FREE_FULL    = 3'd2,
        ERR_REL_UNLOCKED = 3'd3,
        ERR_LOCK_SAT     = 3'd4
    } t_err;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PHYS_W-1:0] push_reg;
    } t_fl_ctrl;

    typedef struct packed {
        logic [PHYS_W-1:0] head_reg;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  count_next;
    } t_fl_stat;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PHYS_W-1:0] phys_reg;
        logic [LOG_W-1:0]  log_reg;
        logic              ready_value;
    } t_req;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_out;
        logic              flag_out;
        logic              is_mapped;
        logic [CNT_W-1:0]  free_count;
        logic              list_empty;
        logic [ERR_W-1:0]  error;
    } t_rsp;

endpackage

/* sv/rrt_if.sv */
// Request and result channels of the register rename table.
// Depends on rrt_pkg for field widths.
interface rrt_req_if import rrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PHYS_W-1:0] phys_reg;
    logic [LOG_W-1:0]  log_reg;
    logic              ready_value;

    modport source (output valid, mode, phys_reg, log_reg, ready_value, input ready);
    modport sink   (input valid, mode, phys_reg, log_reg, ready_value, output ready);
endinterface

interface rrt_rsp_if import rrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PHYS_W-1:0] phys_out;
    logic              flag_out;
    logic              is_mapped;
    logic [CNT_W-1:0]  free_count;
    logic              list_empty;
    logic [ERR_W-1:0]  error;

    modport source (output valid, phys_out, flag_out, is_mapped, free_count, list_empty,
                    error, input ready);
    modport sink   (input valid, phys_out, flag_out, is_mapped, free_count, list_empty,
                    error, output ready);
endinterface

/* sv/rrt_free_list.sv */
// Circular free list of physical registers, full with 0..NUM_PHYS-1 after reset.
// Depends on rrt_pkg.
module rrt_free_list import rrt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fl_ctrl i_ctrl,
    output t_fl_stat o_stat
);

    logic [PHYS_W-1:0] r_slots [NUM_PHYS];
    logic [PHYS_W-1:0] r_head, n_head;
    logic [PHYS_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic [PHYS_W-1:0] next_slot(input logic [PHYS_W-1:0] p);
        return (p == PHYS_W'(NUM_PHYS - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head  = next_slot(r_head);
            n_count = r_count - 1'b1;
        end
        if (i_ctrl.push) begin
            n_tail  = next_slot(r_tail);
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= CNT_W'(NUM_PHYS);
            for (int i = 0; i < NUM_PHYS; i++) begin
                r_slots[i] <= PHYS_W'(i);
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_ctrl.push) begin
                r_slots[r_tail] <= i_ctrl.push_reg;
            end
        end
    end

    assign o_stat.head_reg   = r_slots[r_head];
    assign o_stat.count      = r_count;
    assign o_stat.count_next = n_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_PHYS))
        else $error("free list count above capacity");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_count != '0) && !i_ctrl.push)
        else $error("pop from empty free list or pop with push");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not drop the count");

endmodule

/* sv/register_rename_table.sv */
// Register rename table: free list, alias table, ready bits and lock counts.
// Timing: the request passes a request register, then a result register; one request per cycle
//   sustained while the result side is ready, set by the single update pass.
// Reset (synchronous, active low): free list full with registers 0..15 in order,
//   all logical registers unmapped, ready bits and lock counts cleared.
// Depends on rrt_pkg, rrt_if and rrt_free_list.
module register_rename_table import rrt_pkg::*; #(
    parameter int LOCK_BITS = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rrt_req_if.sink   i_req,
    rrt_rsp_if.source o_rsp
);

    // Request register and result register
    logic r_req_vld;
    t_req r_req;
    logic r_rsp_vld;
    t_rsp r_rsp, n_rsp;

    // Rename state
    logic [PHYS_W-1:0]    r_alias  [NUM_LOGICAL];
    logic [NUM_LOGICAL-1:0] r_mapped;
    logic [NUM_PHYS-1:0]  r_ready;
    logic [LOCK_BITS-1:0] r_lock   [NUM_PHYS];

    logic                 w_adv;
    logic [LOCK_BITS-1:0] w_lock_cnt;
    logic                 w_lock_inc;
    logic                 w_lock_dec;
    logic                 w_map_we;
    logic                 w_rdy_we;
    logic                 w_rdy_val;
    t_fl_ctrl             w_fl_ctrl;
    t_fl_stat             w_fl_stat;

    rrt_free_list u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_fl_ctrl),
        .o_stat  (w_fl_stat)
    );

    // Advance the held request when the result register is free or being drained.
    assign w_adv       = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || w_adv;
    assign w_lock_cnt  = r_lock[r_req.phys_reg];

    // Decode the held request against the current state.
    always_comb begin
        w_lock_inc         = 1'b0;
        w_lock_dec         = 1'b0;
        w_map_we           = 1'b0;
        w_rdy_we           = 1'b0;
        w_rdy_val          = 1'b0;
        w_fl_ctrl.push     = 1'b0;
        w_fl_ctrl.pop      = 1'b0;
        w_fl_ctrl.push_reg = r_req.phys_reg;
        n_rsp              = '0;
        case (r_req.mode)
            MODE_ALLOC: begin
                if (w_fl_stat.count == '0) begin
                    n_rsp.error = ERR_ALLOC_EMPTY;
                end else begin
                    w_fl_ctrl.pop  = w_adv;
                    n_rsp.phys_out = w_fl_stat.head_reg;
                end
            end
            MODE_FREE: begin
                // A register already on the list is not detected; push it again.
                if (w_fl_stat.count == CNT_W'(NUM_PHYS)) begin
                    n_rsp.error = ERR_FREE_FULL;
                end else begin
                    w_fl_ctrl.push = w_adv;
                end
            end
            MODE_LOCK: begin
                if (&w_lock_cnt) begin
                    n_rsp.error = ERR_LOCK_SAT;
                end else begin
                    w_lock_inc = w_adv;
                end
            end
            MODE_RELEASE: begin
                if (w_lock_cnt == '0) begin
                    n_rsp.error = ERR_REL_UNLOCKED;
                end else begin
                    w_lock_dec = w_adv;
                end
            end
            MODE_CHECK_LOCK: begin
                n_rsp.flag_out = (w_lock_cnt != '0);
            end
            MODE_MAP_WRITE: begin
                w_map_we  = w_adv;
                w_rdy_we  = w_adv;
                w_rdy_val = 1'b0;
            end
            MODE_MAP_READ: begin
                if (r_mapped[r_req.log_reg]) begin
                    n_rsp.phys_out  = r_alias[r_req.log_reg];
                    n_rsp.is_mapped = 1'b1;
                end
            end
            MODE_SET_READY: begin
                w_rdy_we  = w_adv;
                w_rdy_val = r_req.ready_value;
            end
            MODE_READ_READY: begin
                n_rsp.flag_out = r_ready[r_req.phys_reg];
            end
            default: begin
                // Unused modes leave the state alone and report zeros apart from the free list status.
            end
        endcase
        // Report the free list as it stands after this request.
        n_rsp.free_count = w_fl_stat.count_next;
        n_rsp.list_empty = (w_fl_stat.count_next == '0);
    end

    // Handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_req_vld <= i_req.valid;
            end
            if (w_adv) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request on accept and the result on advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.mode        <= i_req.mode;
            r_req.phys_reg    <= i_req.phys_reg;
            r_req.log_reg     <= i_req.log_reg;
            r_req.ready_value <= i_req.ready_value;
        end
        if (w_adv) begin
            r_rsp <= n_rsp;
        end
    end

    // Rename state updates, applied as the request moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= '0;
            r_ready  <= '0;
            for (int i = 0; i < NUM_LOGICAL; i++) begin
                r_alias[i] <= '0;
            end
            for (int i = 0; i < NUM_PHYS; i++) begin
                r_lock[i] <= '0;
            end
        end else begin
            if (w_map_we) begin
                r_alias[r_req.log_reg]  <= r_req.phys_reg;
                r_mapped[r_req.log_reg] <= 1'b1;
            end
            if (w_rdy_we) begin
                r_ready[r_req.phys_reg] <= w_rdy_val;
            end
            if (w_lock_inc) begin
                r_lock[r_req.phys_reg] <= w_lock_cnt + 1'b1;
            end else if (w_lock_dec) begin
                r_lock[r_req.phys_reg] <= w_lock_cnt - 1'b1;
            end
        end
    end

    assign o_rsp.valid      = r_rsp_vld;
    assign o_rsp.phys_out   = r_rsp.phys_out;
    assign o_rsp.flag_out   = r_rsp.flag_out;
    assign o_rsp.is_mapped  = r_rsp.is_mapped;
    assign o_rsp.free_count = r_rsp.free_count;
    assign o_rsp.list_empty = r_rsp.list_empty;
    assign o_rsp.error      = r_rsp.error;

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_rsp_vld)
        else $error("advanced request produced no result");

    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && (r_rsp.error == ERR_ALLOC_EMPTY) |-> r_rsp.list_empty
            && (r_rsp.phys_out == '0))
        else $error("alloc error with nonempty list or data");

    a_mapped_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && r_rsp.is_mapped |-> (r_rsp.error == ERR_OK) && !r_rsp.flag_out)
        else $error("map read result carries error or flag");

    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_lock_inc && w_lock_dec) && !(w_map_we && (w_fl_ctrl.push || w_fl_ctrl.pop)))
        else $error("conflicting state updates from one request");

endmodule
